FILE: sv/mp2_pkg.sv
package mp2_pkg;

    localparam int EXP_BITS = 31;
    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int LANES    = 8;

    localparam logic [DATA_W-1:0] ENTRY_ZERO = '0;
    localparam logic [DATA_W-1:0] ENTRY_ONE  = DATA_W'(1);

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] d;
    } t_mat;

    typedef enum logic {
        OP_MUL,
        OP_SQR
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQR,
        S_WAIT1,
        S_WAIT2,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        t_op  op;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

FILE: sv/matrix_power_2x2.sv
// Raises a 2x2 matrix of unsigned 64-bit entries to a 31-bit power by binary
// square-and-multiply, with all arithmetic wrapping modulo 2^64; an exponent
// of zero gives the identity. One request is worked on at a time. Each
// exponent bit up to the highest set one passes through the states MUL, SQR,
// WAIT1 and WAIT2: the multiply and the square go through one shared
// three-stage matrix product unit of eight 64-bit product lanes, and the next
// bit waits for the square to write back. The result sits in an output
// register, so a new request is accepted while the last result still waits
// to be taken.
module matrix_power_2x2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mp2_pkg::DATA_W-1:0]    i_m_top_left,
    input  logic [mp2_pkg::DATA_W-1:0]    i_m_top_right,
    input  logic [mp2_pkg::DATA_W-1:0]    i_m_bottom_left,
    input  logic [mp2_pkg::DATA_W-1:0]    i_m_bottom_right,
    input  logic [mp2_pkg::EXP_BITS-1:0]  i_exponent,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mp2_pkg::DATA_W-1:0]    o_r_top_left,
    output logic [mp2_pkg::DATA_W-1:0]    o_r_top_right,
    output logic [mp2_pkg::DATA_W-1:0]    o_r_bottom_left,
    output logic [mp2_pkg::DATA_W-1:0]    o_r_bottom_right
);

    mp2_pkg::t_dp_cmd cmd;
    mp2_pkg::t_dp_sts sts;

    mp2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_exponent  (i_exponent),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mp2_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_m_top_left     (i_m_top_left),
        .i_m_top_right    (i_m_top_right),
        .i_m_bottom_left  (i_m_bottom_left),
        .i_m_bottom_right (i_m_bottom_right),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_r_top_left     (o_r_top_left),
        .o_r_top_right    (o_r_top_right),
        .o_r_bottom_left  (o_r_bottom_left),
        .o_r_bottom_right (o_r_bottom_right)
    );

endmodule

FILE: sv/mp2_ctrl.sv
module mp2_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mp2_pkg::EXP_BITS-1:0]  i_exponent,
    input  logic                          i_out_ready,
    input  mp2_pkg::t_dp_sts              i_sts,
    output mp2_pkg::t_dp_cmd              o_cmd
);

    mp2_pkg::t_state r_state;
    mp2_pkg::t_state n_state;
    logic [mp2_pkg::EXP_BITS-1:0] r_exp;
    logic [mp2_pkg::EXP_BITS-1:0] n_exp;
    logic exp_rest;
    logic out_free;
    logic in_fire;

    assign exp_rest = (r_exp >> 1) != '0;
    assign out_free = !i_sts.out_full || i_out_ready;
    assign in_fire  = i_in_valid && (r_state == mp2_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mp2_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
    end

    always_comb begin
        n_exp = r_exp;
        if (in_fire) begin
            n_exp = i_exponent;
        end else if (r_state == mp2_pkg::S_SQR) begin
            n_exp = r_exp >> 1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mp2_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mp2_pkg::S_MUL;
                end
            end
            mp2_pkg::S_MUL: begin
                if (r_exp == '0) begin
                    n_state = mp2_pkg::S_FINISH;
                end else begin
                    n_state = mp2_pkg::S_SQR;
                end
            end
            mp2_pkg::S_SQR:   n_state = mp2_pkg::S_WAIT1;
            mp2_pkg::S_WAIT1: n_state = mp2_pkg::S_WAIT2;
            mp2_pkg::S_WAIT2: n_state = mp2_pkg::S_MUL;
            mp2_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = mp2_pkg::S_IDLE;
                end
            end
            default: n_state = mp2_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.op       = mp2_pkg::OP_MUL;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            mp2_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mp2_pkg::S_MUL: begin
                o_cmd.issue = r_exp[0];
            end
            mp2_pkg::S_SQR: begin
                o_cmd.issue = exp_rest;
                o_cmd.op    = mp2_pkg::OP_SQR;
            end
            mp2_pkg::S_WAIT1, mp2_pkg::S_WAIT2: begin
            end
            mp2_pkg::S_FINISH: begin
                o_cmd.load_out = out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: sv/mp2_dpath.sv
module mp2_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mp2_pkg::t_dp_cmd            i_cmd,
    output mp2_pkg::t_dp_sts            o_sts,
    input  logic [mp2_pkg::DATA_W-1:0]  i_m_top_left,
    input  logic [mp2_pkg::DATA_W-1:0]  i_m_top_right,
    input  logic [mp2_pkg::DATA_W-1:0]  i_m_bottom_left,
    input  logic [mp2_pkg::DATA_W-1:0]  i_m_bottom_right,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mp2_pkg::DATA_W-1:0]  o_r_top_left,
    output logic [mp2_pkg::DATA_W-1:0]  o_r_top_right,
    output logic [mp2_pkg::DATA_W-1:0]  o_r_bottom_left,
    output logic [mp2_pkg::DATA_W-1:0]  o_r_bottom_right
);

    localparam int DW = mp2_pkg::DATA_W;
    localparam int HW = mp2_pkg::HALF_W;
    localparam int NL = mp2_pkg::LANES;

    mp2_pkg::t_mat r_acc;
    mp2_pkg::t_mat r_base;
    mp2_pkg::t_mat r_out;
    mp2_pkg::t_mat x;
    mp2_pkg::t_mat y;
    mp2_pkg::t_mat wb;
    logic r_out_valid;

    logic [DW-1:0] xa [NL];
    logic [DW-1:0] ya [NL];

    logic [DW-1:0] r_ll   [NL];
    logic [HW-1:0] r_lh   [NL];
    logic [HW-1:0] r_hl   [NL];
    logic [DW-1:0] r_prod [NL];

    logic         r_v1;
    logic         r_v2;
    mp2_pkg::t_op r_op1;
    mp2_pkg::t_op r_op2;

    always_comb begin
        x = (i_cmd.op == mp2_pkg::OP_SQR) ? r_base : r_acc;
        y = r_base;
        xa[0] = x.a; ya[0] = y.a;
        xa[1] = x.b; ya[1] = y.c;
        xa[2] = x.a; ya[2] = y.b;
        xa[3] = x.b; ya[3] = y.d;
        xa[4] = x.c; ya[4] = y.a;
        xa[5] = x.d; ya[5] = y.c;
        xa[6] = x.c; ya[6] = y.b;
        xa[7] = x.d; ya[7] = y.d;
    end

    // Each 64-bit product modulo 2^64 is split into one full low-half
    // product and two cross products of which only the low half survives.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            for (int k = 0; k < NL; k++) begin
                r_ll[k] <= DW'(xa[k][HW-1:0]) * DW'(ya[k][HW-1:0]);
                r_lh[k] <= xa[k][HW-1:0] * ya[k][DW-1:HW];
                r_hl[k] <= xa[k][DW-1:HW] * ya[k][HW-1:0];
            end
        end
        if (r_v1) begin
            for (int k = 0; k < NL; k++) begin
                r_prod[k] <= r_ll[k] + {r_lh[k] + r_hl[k], HW'(0)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1 <= i_cmd.op;
        r_op2 <= r_op1;
    end

    always_comb begin
        wb.a = r_prod[0] + r_prod[1];
        wb.b = r_prod[2] + r_prod[3];
        wb.c = r_prod[4] + r_prod[5];
        wb.d = r_prod[6] + r_prod[7];
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load) begin
            r_base.a <= i_m_top_left;
            r_base.b <= i_m_top_right;
            r_base.c <= i_m_bottom_left;
            r_base.d <= i_m_bottom_right;
            r_acc.a  <= mp2_pkg::ENTRY_ONE;
            r_acc.b  <= mp2_pkg::ENTRY_ZERO;
            r_acc.c  <= mp2_pkg::ENTRY_ZERO;
            r_acc.d  <= mp2_pkg::ENTRY_ONE;
        end else if (r_v2) begin
            if (r_op2 == mp2_pkg::OP_SQR) begin
                r_base <= wb;
            end else begin
                r_acc <= wb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_acc;
        end
    end

    assign o_sts.out_full   = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_r_top_left     = r_out.a;
    assign o_r_top_right    = r_out.b;
    assign o_r_bottom_left  = r_out.c;
    assign o_r_bottom_right = r_out.d;

endmodule

FILE: sv/mp2_chk.sv
module mp2_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [mp2_pkg::EXP_BITS-1:0]  i_exponent,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mp2_pkg::DATA_W-1:0]    o_r_top_left,
    input logic [mp2_pkg::DATA_W-1:0]    o_r_top_right,
    input logic [mp2_pkg::DATA_W-1:0]    o_r_bottom_left,
    input logic [mp2_pkg::DATA_W-1:0]    o_r_bottom_right
);

    logic in_fire;
    logic out_stall;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> o_out_valid)
        else $error("Result valid dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> ($stable(o_r_top_left) && $stable(o_r_top_right) &&
                       $stable(o_r_bottom_left) && $stable(o_r_bottom_right)))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("Block took a new request while still computing.");

    a_zero_exp_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_exponent == '0 && !o_out_valid) |-> ##3
        (o_out_valid && o_r_top_left == mp2_pkg::ENTRY_ONE &&
         o_r_top_right == mp2_pkg::ENTRY_ZERO &&
         o_r_bottom_left == mp2_pkg::ENTRY_ZERO &&
         o_r_bottom_right == mp2_pkg::ENTRY_ONE))
        else $error("Exponent zero did not give the identity on time.");

endmodule

bind matrix_power_2x2 mp2_chk u_mp2_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_exponent       (i_exponent),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_r_top_left     (o_r_top_left),
    .o_r_top_right    (o_r_top_right),
    .o_r_bottom_left  (o_r_bottom_left),
    .o_r_bottom_right (o_r_bottom_right)
);
